/* sv/shs_pkg.sv */
// Shared types, codes and reset constants for the stepper axis homing supervisor.
`timescale 1ns / 1ps

package shs_pkg;

  // Supervisor states, numbered densely
  typedef enum logic [4:0] {
    ST_NOTVALID    = 5'd0,
    ST_STANDBY     = 5'd1,
    ST_HOLD_FWD    = 5'd2,
    ST_HOLD_REV    = 5'd3,
    ST_MOVE_FWD    = 5'd4,
    ST_MOVE_REV    = 5'd5,
    ST_DIRTY       = 5'd6,
    ST_ERROR       = 5'd7,
    ST_C_NEXT      = 5'd8,
    ST_C_START     = 5'd9,
    ST_C_FWD_START = 5'd10,
    ST_C_FWD       = 5'd11,
    ST_C_FWD_FIN   = 5'd12,
    ST_C_REV_START = 5'd13,
    ST_C_REV       = 5'd14,
    ST_C_REV_FIN   = 5'd15,
    ST_C_FIN       = 5'd16
  } sup_state_t;

  // Error codes
  typedef enum logic [2:0] {
    ER_NONE      = 3'd0,
    ER_TIMEOUT   = 3'd1,
    ER_WRONG_DIR = 3'd2,
    ER_BLOCKED   = 3'd3,
    ER_START     = 3'd4,
    ER_STOP      = 3'd5,
    ER_MOVED     = 3'd6,
    ER_ESTOP     = 3'd7
  } err_code_t;

  // Input word function codes
  localparam logic [2:0] FN_TICK   = 3'd0;
  localparam logic [2:0] FN_SWITCH = 3'd1;
  localparam logic [2:0] FN_CALIB  = 3'd2;
  localparam logic [2:0] FN_ESTOP  = 3'd3;
  localparam logic [2:0] FN_FWD    = 3'd4;
  localparam logic [2:0] FN_REV    = 3'd5;

  // Switch states
  localparam logic [1:0] SW_STANDBY = 2'd0;
  localparam logic [1:0] SW_ACTIVE  = 2'd1;

  // Motor direction patterns
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd3;

  // Switch ids and edge kinds
  localparam logic SWID_FWD  = 1'b0;
  localparam logic SWID_REV  = 1'b1;
  localparam logic EDGE_DOWN = 1'b0;

  // Configuration register indexes
  localparam logic [2:0] CFG_TIMEOUT     = 3'd0;
  localparam logic [2:0] CFG_CALIB_SPAN  = 3'd1;
  localparam logic [2:0] CFG_CALIB_SPEED = 3'd2;
  localparam logic [2:0] CFG_CALIB_ACCEL = 3'd3;
  localparam logic [2:0] CFG_RUN_SPEED   = 3'd4;
  localparam logic [2:0] CFG_RUN_ACCEL   = 3'd5;

  // Reset values
  localparam logic [15:0] RST_TIMEOUT     = 16'd5000;
  localparam logic [30:0] RST_CALIB_SPAN  = 31'd12800;
  localparam logic [15:0] RST_CALIB_SPEED = 16'd50;
  localparam logic [15:0] RST_CALIB_ACCEL = 16'd25;
  localparam logic [15:0] RST_RUN_SPEED   = 16'd200;
  localparam logic [15:0] RST_RUN_ACCEL   = 16'd50;

  typedef struct packed {
    logic [15:0] move_timeout_ms;
    logic [30:0] calib_span;
    logic [15:0] calib_speed;
    logic [15:0] calib_accel;
    logic [15:0] run_speed;
    logic [15:0] run_accel;
  } shs_cfg_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] now_ms;
    logic [1:0]  fwd_switch;
    logic [1:0]  rev_switch;
    logic [1:0]  motor_dir;
    logic        motor_on;
    logic [31:0] motor_pos;
    logic        switch_id;
    logic        switch_edge;
  } shs_item_t;

  typedef struct packed {
    logic        cmd_stop;
    logic        cmd_disable;
    logic        cmd_move;
    logic [31:0] move_target;
    logic        cmd_zero_pos;
    logic        cmd_profile;
    logic [15:0] speed_out;
    logic [15:0] accel_out;
    logic [4:0]  sys_state_out;
    logic [2:0]  error_out;
    logic        state_changed;
    logic        move_accepted;
  } shs_result_t;

endpackage

/* sv/shs_cfg_regs.sv */
// Configuration register file for the homing supervisor.
`timescale 1ns / 1ps

module shs_cfg_regs
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  output shs_cfg_t    cfg
);

  shs_cfg_t cfg_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.move_timeout_ms <= RST_TIMEOUT;
      cfg_r.calib_span      <= RST_CALIB_SPAN;
      cfg_r.calib_speed     <= RST_CALIB_SPEED;
      cfg_r.calib_accel     <= RST_CALIB_ACCEL;
      cfg_r.run_speed       <= RST_RUN_SPEED;
      cfg_r.run_accel       <= RST_RUN_ACCEL;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_TIMEOUT:     cfg_r.move_timeout_ms <= wr_data[15:0];
        CFG_CALIB_SPAN:  cfg_r.calib_span      <= wr_data[30:0];
        CFG_CALIB_SPEED: cfg_r.calib_speed     <= wr_data[15:0];
        CFG_CALIB_ACCEL: cfg_r.calib_accel     <= wr_data[15:0];
        CFG_RUN_SPEED:   cfg_r.run_speed       <= wr_data[15:0];
        CFG_RUN_ACCEL:   cfg_r.run_accel       <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/shs_core.sv */
// Supervisor state registers and the single-pass next-state and command logic.
`timescale 1ns / 1ps

module shs_core
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  shs_item_t   item,
  input  shs_cfg_t    cfg,
  output shs_result_t res
);

  sup_state_t  st_r, st_nxt;
  sup_state_t  seen_r, seen_nxt;
  err_code_t   err_r, err_nxt;
  logic [1:0]  last_dir_r, last_dir_nxt;
  logic [31:0] start_ms_r, start_ms_nxt;
  logic [31:0] fwd_lim_r, fwd_lim_nxt;
  logic [31:0] rev_lim_r, rev_lim_nxt;
  logic        fwd_done_r, fwd_done_nxt;
  logic        rev_done_r, rev_done_nxt;

  logic [31:0] elapsed;
  logic        timed_out;
  logic        run_state;
  logic [1:0]  move_sw;
  logic [31:0] span_ext;

  // Move timer, shared by the tick check and the calibration run checks
  assign elapsed   = item.now_ms - start_ms_r;
  assign timed_out = elapsed > {16'd0, cfg.move_timeout_ms};
  assign run_state = (st_r >= ST_STANDBY) && (st_r <= ST_MOVE_REV);
  assign move_sw   = (item.func == FN_FWD) ? item.fwd_switch : item.rev_switch;
  assign span_ext  = {1'b0, cfg.calib_span};

  always_comb begin
    st_nxt       = st_r;
    seen_nxt     = seen_r;
    err_nxt      = err_r;
    last_dir_nxt = last_dir_r;
    start_ms_nxt = start_ms_r;
    fwd_lim_nxt  = fwd_lim_r;
    rev_lim_nxt  = rev_lim_r;
    fwd_done_nxt = fwd_done_r;
    rev_done_nxt = rev_done_r;
    res          = '0;

    unique case (item.func)
      FN_TICK: begin
        // follow the reported move direction
        if (item.motor_dir != last_dir_r) begin
          last_dir_nxt = item.motor_dir;
          if (run_state) begin
            unique case (item.motor_dir)
              DIR_STOP: begin
                if (item.motor_on) begin
                  if (item.fwd_switch == SW_ACTIVE) begin
                    st_nxt = ST_HOLD_FWD;
                  end else if (item.rev_switch == SW_ACTIVE) begin
                    st_nxt = ST_HOLD_REV;
                  end else begin
                    err_nxt = ER_STOP;
                    res.cmd_disable = 1'b1;
                    st_nxt = ST_ERROR;
                  end
                end else begin
                  st_nxt = ST_STANDBY;
                end
              end
              DIR_FWD: st_nxt = ST_MOVE_FWD;
              DIR_REV: st_nxt = ST_MOVE_REV;
              default: ;
            endcase
          end
        end
        // move timeout
        if (last_dir_nxt != DIR_STOP && timed_out) begin
          res.cmd_stop    = 1'b1;
          res.cmd_disable = 1'b1;
          err_nxt         = ER_TIMEOUT;
          st_nxt          = ST_ERROR;
        end
        // state change report
        if (seen_r != st_nxt) begin
          seen_nxt          = st_nxt;
          res.state_changed = 1'b1;
        end
        // calibration sequence
        unique case (st_nxt)
          ST_C_START: begin
            fwd_lim_nxt      = span_ext;
            rev_lim_nxt      = 32'd0 - span_ext;
            res.cmd_zero_pos = 1'b1;
            res.cmd_profile  = 1'b1;
            res.speed_out    = cfg.calib_speed;
            res.accel_out    = cfg.calib_accel;
            err_nxt          = ER_NONE;
            fwd_done_nxt     = 1'b0;
            rev_done_nxt     = 1'b0;
            st_nxt           = ST_C_NEXT;
          end
          ST_C_NEXT: begin
            if (fwd_done_r && rev_done_r) begin
              st_nxt = ST_C_FIN;
            end else if (!fwd_done_r) begin
              st_nxt = (item.fwd_switch == SW_STANDBY) ? ST_C_FWD_START : ST_C_REV_START;
            end else if (item.rev_switch == SW_STANDBY) begin
              st_nxt = ST_C_REV_START;
            end else begin
              err_nxt = ER_BLOCKED;
              res.cmd_disable = 1'b1;
              st_nxt = ST_ERROR;
            end
          end
          ST_C_FWD_START: begin
            if (item.fwd_switch == SW_STANDBY) begin
              start_ms_nxt    = item.now_ms;
              res.cmd_move    = 1'b1;
              res.move_target = fwd_lim_r;
              st_nxt          = ST_C_FWD;
            end else begin
              err_nxt = ER_START;
              res.cmd_disable = 1'b1;
              st_nxt = ST_ERROR;
            end
          end
          ST_C_REV_START: begin
            if (item.rev_switch == SW_STANDBY) begin
              start_ms_nxt    = item.now_ms;
              res.cmd_move    = 1'b1;
              res.move_target = rev_lim_r;
              st_nxt          = ST_C_REV;
            end else begin
              err_nxt = ER_START;
              res.cmd_disable = 1'b1;
              st_nxt = ST_ERROR;
            end
          end
          ST_C_FWD, ST_C_REV: begin
            if (((st_nxt == ST_C_FWD) ? item.fwd_switch : item.rev_switch) == SW_ACTIVE) begin
              res.cmd_stop = 1'b1;
              st_nxt = (st_nxt == ST_C_FWD) ? ST_C_FWD_FIN : ST_C_REV_FIN;
            end else if (last_dir_nxt == DIR_STOP) begin
              err_nxt = ER_STOP;
              res.cmd_disable = 1'b1;
              st_nxt = ST_ERROR;
            end else if (timed_out) begin
              res.cmd_stop    = 1'b1;
              err_nxt         = ER_TIMEOUT;
              res.cmd_disable = 1'b1;
              st_nxt          = ST_ERROR;
            end
          end
          ST_C_FWD_FIN: begin
            fwd_lim_nxt  = item.motor_pos;
            fwd_done_nxt = 1'b1;
            st_nxt       = ST_C_NEXT;
          end
          ST_C_REV_FIN: begin
            rev_lim_nxt  = item.motor_pos;
            rev_done_nxt = 1'b1;
            st_nxt       = ST_C_NEXT;
          end
          ST_C_FIN: begin
            res.cmd_profile = 1'b1;
            res.speed_out   = cfg.run_speed;
            res.accel_out   = cfg.run_accel;
            if (item.fwd_switch == SW_ACTIVE) begin
              st_nxt = ST_HOLD_FWD;
            end else if (item.rev_switch == SW_ACTIVE) begin
              st_nxt = ST_HOLD_REV;
            end
          end
          default: ;
        endcase
      end
      FN_SWITCH: begin
        if (item.switch_edge == EDGE_DOWN) begin
          res.cmd_stop = 1'b1;
          if ((item.switch_id == SWID_FWD && st_r == ST_C_REV) ||
              (item.switch_id == SWID_REV && st_r == ST_C_FWD)) begin
            err_nxt = ER_WRONG_DIR;
            res.cmd_disable = 1'b1;
            st_nxt = ST_ERROR;
          end
        end else if (st_r == ST_STANDBY || st_r == ST_HOLD_FWD || st_r == ST_HOLD_REV) begin
          // released switch: disable only, no stop
          err_nxt = ER_MOVED;
          res.cmd_disable = 1'b1;
          st_nxt = ST_ERROR;
        end
      end
      FN_CALIB: st_nxt = ST_C_START;
      FN_ESTOP: begin
        res.cmd_stop    = 1'b1;
        res.cmd_disable = 1'b1;
        err_nxt         = ER_ESTOP;
        st_nxt          = ST_ERROR;
      end
      FN_FWD, FN_REV: begin
        if (run_state && move_sw == SW_STANDBY) begin
          start_ms_nxt      = item.now_ms;
          res.cmd_move      = 1'b1;
          res.move_target   = (item.func == FN_FWD) ? fwd_lim_r : rev_lim_r;
          res.move_accepted = 1'b1;
        end
      end
      default: ;
    endcase

    res.sys_state_out = st_nxt;
    res.error_out     = err_nxt;
  end

  // Supervisor state, updated once per processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_DIRTY;
      seen_r     <= ST_DIRTY;
      err_r      <= ER_NONE;
      last_dir_r <= DIR_STOP;
      start_ms_r <= 32'd0;
      fwd_lim_r  <= {1'b0, RST_CALIB_SPAN};
      rev_lim_r  <= 32'd0 - {1'b0, RST_CALIB_SPAN};
      fwd_done_r <= 1'b0;
      rev_done_r <= 1'b0;
    end else if (step) begin
      st_r       <= st_nxt;
      seen_r     <= seen_nxt;
      err_r      <= err_nxt;
      last_dir_r <= last_dir_nxt;
      start_ms_r <= start_ms_nxt;
      fwd_lim_r  <= fwd_lim_nxt;
      rev_lim_r  <= rev_lim_nxt;
      fwd_done_r <= fwd_done_nxt;
      rev_done_r <= rev_done_nxt;
    end
  end

endmodule

/* sv/stepper_axis_homing_supervisor.sv */
// Top level of the stepper axis homing supervisor: input and result registers.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------
//   in      | in_valid / in_ready    | func, now_ms, switches, motor status
//   out     | out_valid / out_ready  | motor commands, state, error, flags
//   cfg     | cfg_valid / cfg_ready  | cfg_index (3), cfg_data (32)
//
// One word per cycle sustained while out_ready is high; each word passes the
// input register, then the result register, its result set by the single-pass
// supervisor logic between them. Supervisor state advances when the input
// register moves into the result register. A stalled out_ready holds the
// result and backs up into the input register. Synchronous reset restores
// the register defaults and the dirty state; cfg_ready is always high.
`timescale 1ns / 1ps

module stepper_axis_homing_supervisor
  import shs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_func,
  input  logic [31:0]        in_now_ms,
  input  logic [1:0]         in_fwd_switch,
  input  logic [1:0]         in_rev_switch,
  input  logic signed [1:0]  in_motor_dir,
  input  logic               in_motor_on,
  input  logic signed [31:0] in_motor_pos,
  input  logic               in_switch_id,
  input  logic               in_switch_edge,
  // result words
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_cmd_stop,
  output logic               out_cmd_disable,
  output logic               out_cmd_move,
  output logic signed [31:0] out_move_target,
  output logic               out_cmd_zero_pos,
  output logic               out_cmd_profile,
  output logic [15:0]        out_speed_out,
  output logic [15:0]        out_accel_out,
  output logic [4:0]         out_sys_state_out,
  output logic [2:0]         out_error_out,
  output logic               out_state_changed,
  output logic               out_move_accepted,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  shs_cfg_t    cfg;
  shs_item_t   item_r;
  logic        item_vld_r;
  shs_result_t res;
  shs_result_t res_r;
  logic        res_vld_r;
  logic        step;

  // Pipeline flow
  assign step      = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready  = !item_vld_r || step;
  assign cfg_ready = 1'b1;

  shs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  shs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.func        <= in_func;
      item_r.now_ms      <= in_now_ms;
      item_r.fwd_switch  <= in_fwd_switch;
      item_r.rev_switch  <= in_rev_switch;
      item_r.motor_dir   <= in_motor_dir;
      item_r.motor_on    <= in_motor_on;
      item_r.motor_pos   <= in_motor_pos;
      item_r.switch_id   <= in_switch_id;
      item_r.switch_edge <= in_switch_edge;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (!res_vld_r || out_ready) begin
      res_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid         = res_vld_r;
  assign out_cmd_stop      = res_r.cmd_stop;
  assign out_cmd_disable   = res_r.cmd_disable;
  assign out_cmd_move      = res_r.cmd_move;
  assign out_move_target   = res_r.move_target;
  assign out_cmd_zero_pos  = res_r.cmd_zero_pos;
  assign out_cmd_profile   = res_r.cmd_profile;
  assign out_speed_out     = res_r.speed_out;
  assign out_accel_out     = res_r.accel_out;
  assign out_sys_state_out = res_r.sys_state_out;
  assign out_error_out     = res_r.error_out;
  assign out_state_changed = res_r.state_changed;
  assign out_move_accepted = res_r.move_accepted;

endmodule

/* tb/stepper_axis_homing_supervisor_tb.sv */
// Self-checking testbench for the stepper axis homing supervisor.
`timescale 1ns / 1ps

module stepper_axis_homing_supervisor_tb;
  import shs_pkg::*;

  // Codes the package does not name
  localparam logic [2:0] FN_SPARE6  = 3'd6;
  localparam logic [2:0] FN_SPARE7  = 3'd7;
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam logic [1:0] DIR_MINUS2 = 2'b10;
  localparam logic       EDGE_UP    = 1'b1;

  // Predicts one report per accepted word and checks reports in order
  class axis_scoreboard;
    // register mirror
    logic [15:0] timeout_ms, calib_speed, calib_accel, run_speed, run_accel;
    logic [30:0] span;
    // supervisor state
    sup_state_t  sup, seen;
    err_code_t   err;
    logic [1:0]  last_dir;
    logic [31:0] move_t0, fwd_lim, rev_lim, now;
    bit          fwd_done, rev_done;
    shs_result_t rep;
    shs_result_t expected_reports[$];
    int fail_count, checked, faults, calib_passes, moves_started;

    function new();
      timeout_ms  = RST_TIMEOUT;
      span        = RST_CALIB_SPAN;
      calib_speed = RST_CALIB_SPEED;
      calib_accel = RST_CALIB_ACCEL;
      run_speed   = RST_RUN_SPEED;
      run_accel   = RST_RUN_ACCEL;
      sup = ST_DIRTY;
      seen = ST_DIRTY;
      err = ER_NONE;
      last_dir = DIR_STOP;
      move_t0 = '0;
      fwd_lim = {1'b0, RST_CALIB_SPAN};
      rev_lim = 32'd0 - {1'b0, RST_CALIB_SPAN};
      fwd_done = 1'b0;
      rev_done = 1'b0;
      fail_count = 0;
      checked = 0;
      faults = 0;
      calib_passes = 0;
      moves_started = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        CFG_TIMEOUT:     timeout_ms = d[15:0];
        CFG_CALIB_SPAN:  span = d[30:0];
        CFG_CALIB_SPEED: calib_speed = d[15:0];
        CFG_CALIB_ACCEL: calib_accel = d[15:0];
        CFG_RUN_SPEED:   run_speed = d[15:0];
        CFG_RUN_ACCEL:   run_accel = d[15:0];
        default: ;
      endcase
    endfunction

    function void fault(err_code_t code);
      err = code;
      rep.cmd_disable = 1'b1;
      sup = ST_ERROR;
      faults++;
    endfunction

    function void load_profile(logic [15:0] speed, logic [15:0] accel);
      rep.cmd_profile = 1'b1;
      rep.speed_out = speed;
      rep.accel_out = accel;
    endfunction

    function bit timed_out();
      return (now - move_t0) > {16'd0, timeout_ms};
    endfunction

    function bit in_run();
      return sup >= ST_STANDBY && sup <= ST_MOVE_REV;
    endfunction

    // A move only starts while its switch is in standby
    function bit start_move(bit forward, logic [1:0] sw);
      if (sw != SW_STANDBY) return 1'b0;
      move_t0 = now;
      rep.cmd_move = 1'b1;
      rep.move_target = forward ? fwd_lim : rev_lim;
      moves_started++;
      return 1'b1;
    endfunction

    // Calibration run: stop at the switch, else stall or timeout faults
    function void switch_reached(logic [1:0] sw, sup_state_t nxt);
      if (sw == SW_ACTIVE) begin
        rep.cmd_stop = 1'b1;
        sup = nxt;
      end else if (last_dir == DIR_STOP) begin
        fault(ER_STOP);
      end else if (timed_out()) begin
        rep.cmd_stop = 1'b1;
        fault(ER_TIMEOUT);
      end
    endfunction

    function void note_word(shs_item_t w);
      rep = '0;
      now = w.now_ms;
      case (w.func)
        FN_TICK: begin
          // direction follow-up, only acts in the run states
          if (w.motor_dir != last_dir) begin
            last_dir = w.motor_dir;
            if (in_run()) begin
              if (last_dir == DIR_STOP) begin
                if (w.motor_on) begin
                  if (w.fwd_switch == SW_ACTIVE) sup = ST_HOLD_FWD;
                  else if (w.rev_switch == SW_ACTIVE) sup = ST_HOLD_REV;
                  else fault(ER_STOP);
                end else begin
                  sup = ST_STANDBY;
                end
              end else if (last_dir == DIR_FWD) begin
                sup = ST_MOVE_FWD;
              end else if (last_dir == DIR_REV) begin
                sup = ST_MOVE_REV;
              end
            end
          end
          if (last_dir != DIR_STOP && timed_out()) begin
            rep.cmd_stop = 1'b1;
            fault(ER_TIMEOUT);
          end
          if (seen != sup) begin
            seen = sup;
            rep.state_changed = 1'b1;
          end
          // calibration sequence step
          case (sup)
            ST_C_START: begin
              fwd_lim = {1'b0, span};
              rev_lim = 32'd0 - {1'b0, span};
              rep.cmd_zero_pos = 1'b1;
              load_profile(calib_speed, calib_accel);
              err = ER_NONE;
              fwd_done = 1'b0;
              rev_done = 1'b0;
              sup = ST_C_NEXT;
            end
            ST_C_NEXT: begin
              if (fwd_done && rev_done) begin
                sup = ST_C_FIN;
                calib_passes++;
              end else if (!fwd_done) begin
                if (w.fwd_switch == SW_STANDBY) sup = ST_C_FWD_START;
                else sup = ST_C_REV_START;
              end else if (w.rev_switch == SW_STANDBY) begin
                sup = ST_C_REV_START;
              end else begin
                fault(ER_BLOCKED);
              end
            end
            ST_C_FWD_START: begin
              if (start_move(1'b1, w.fwd_switch)) sup = ST_C_FWD;
              else fault(ER_START);
            end
            ST_C_FWD: switch_reached(w.fwd_switch, ST_C_FWD_FIN);
            ST_C_FWD_FIN: begin
              fwd_lim = w.motor_pos;
              fwd_done = 1'b1;
              sup = ST_C_NEXT;
            end
            ST_C_REV_START: begin
              if (start_move(1'b0, w.rev_switch)) sup = ST_C_REV;
              else fault(ER_START);
            end
            ST_C_REV: switch_reached(w.rev_switch, ST_C_REV_FIN);
            ST_C_REV_FIN: begin
              rev_lim = w.motor_pos;
              rev_done = 1'b1;
              sup = ST_C_NEXT;
            end
            ST_C_FIN: begin
              load_profile(run_speed, run_accel);
              if (w.fwd_switch == SW_ACTIVE) sup = ST_HOLD_FWD;
              else if (w.rev_switch == SW_ACTIVE) sup = ST_HOLD_REV;
            end
            default: ;
          endcase
        end
        FN_SWITCH: begin
          if (w.switch_edge == EDGE_DOWN) begin
            rep.cmd_stop = 1'b1;
            if (w.switch_id == SWID_FWD && sup == ST_C_REV) fault(ER_WRONG_DIR);
            else if (w.switch_id == SWID_REV && sup == ST_C_FWD) fault(ER_WRONG_DIR);
          end else if (sup == ST_STANDBY || sup == ST_HOLD_FWD || sup == ST_HOLD_REV) begin
            // released switch while parked: driver off, no stop
            fault(ER_MOVED);
          end
        end
        FN_CALIB: sup = ST_C_START;
        FN_ESTOP: begin
          rep.cmd_stop = 1'b1;
          fault(ER_ESTOP);
        end
        FN_FWD, FN_REV: begin
          if (in_run() && start_move(w.func == FN_FWD,
                                     (w.func == FN_FWD) ? w.fwd_switch : w.rev_switch))
            rep.move_accepted = 1'b1;
        end
        default: ;
      endcase
      rep.sys_state_out = sup;
      rep.error_out = err;
      expected_reports.push_back(rep);
    endfunction

    function int field_off(string name, logic [31:0] want, logic [31:0] got);
      if (want === got) return 0;
      if (fail_count < 10)
        $display("report %0d %s: expected %0h, actual %0h", checked, name, want, got);
      return 1;
    endfunction

    function void check_report(shs_result_t got);
      shs_result_t want;
      int bad;
      checked++;
      if (expected_reports.size() == 0) begin
        if (fail_count < 10)
          $display("report %0d arrived with nothing expected (state %0d)",
                   checked, got.sys_state_out);
        fail_count++;
        return;
      end
      want = expected_reports.pop_front();
      bad = 0;
      bad += field_off("cmd_stop", 32'(want.cmd_stop), 32'(got.cmd_stop));
      bad += field_off("cmd_disable", 32'(want.cmd_disable), 32'(got.cmd_disable));
      bad += field_off("cmd_move", 32'(want.cmd_move), 32'(got.cmd_move));
      bad += field_off("move_target", want.move_target, got.move_target);
      bad += field_off("cmd_zero_pos", 32'(want.cmd_zero_pos), 32'(got.cmd_zero_pos));
      bad += field_off("cmd_profile", 32'(want.cmd_profile), 32'(got.cmd_profile));
      bad += field_off("speed_out", 32'(want.speed_out), 32'(got.speed_out));
      bad += field_off("accel_out", 32'(want.accel_out), 32'(got.accel_out));
      bad += field_off("sys_state_out", 32'(want.sys_state_out), 32'(got.sys_state_out));
      bad += field_off("error_out", 32'(want.error_out), 32'(got.error_out));
      bad += field_off("state_changed", 32'(want.state_changed), 32'(got.state_changed));
      bad += field_off("move_accepted", 32'(want.move_accepted), 32'(got.move_accepted));
      if (bad != 0) fail_count++;
    endfunction
  endclass

  // Block ports
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_func = '0;
  logic [31:0]        in_now_ms = '0;
  logic [1:0]         in_fwd_switch = '0;
  logic [1:0]         in_rev_switch = '0;
  logic signed [1:0]  in_motor_dir = '0;
  logic               in_motor_on = 1'b0;
  logic signed [31:0] in_motor_pos = '0;
  logic               in_switch_id = 1'b0;
  logic               in_switch_edge = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_cmd_stop, out_cmd_disable, out_cmd_move;
  logic signed [31:0] out_move_target;
  logic               out_cmd_zero_pos, out_cmd_profile;
  logic [15:0]        out_speed_out, out_accel_out;
  logic [4:0]         out_sys_state_out;
  logic [2:0]         out_error_out;
  logic               out_state_changed, out_move_accepted;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  axis_scoreboard sb = new();
  int          tx_gap_pct = 25;
  int          rx_stall_pct = 25;
  int          stall_left = 0;
  int          words_sent = 0;
  logic [31:0] sim_ms = '0;

  stepper_axis_homing_supervisor dut (.*);

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // Result side back-pressure
  always @(posedge clk) begin : rx_stall
    int n;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      n = pick_gap(rx_stall_pct);
      out_ready <= (n == 0);
      stall_left <= (n > 0) ? n - 1 : 0;
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_report({out_cmd_stop, out_cmd_disable, out_cmd_move, out_move_target,
                       out_cmd_zero_pos, out_cmd_profile, out_speed_out, out_accel_out,
                       out_sys_state_out, out_error_out, out_state_changed,
                       out_move_accepted});
  end

  // Hard stop if the run hangs
  initial begin
    #20_000_000;
    $display("stepper_axis_homing_supervisor verification failed");
    $finish;
  end

  // Switch reading: active with the given odds, rarely a debouncing code
  function automatic logic [1:0] pick_switch(int pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < pct) return SW_ACTIVE;
    if (roll >= 96) return 2'($urandom_range(2, 3));
    return SW_STANDBY;
  endfunction

  function automatic shs_item_t compose_word(logic [2:0] fn, logic [1:0] fsw,
                                             logic [1:0] rsw, logic [1:0] dir,
                                             logic [31:0] pos);
    shs_item_t w;
    sim_ms += 3;
    w = '0;
    w.func = fn;
    w.now_ms = sim_ms;
    w.fwd_switch = fsw;
    w.rev_switch = rsw;
    w.motor_dir = dir;
    w.motor_on = 1'b1;
    w.motor_pos = pos;
    w.switch_id = SWID_FWD;
    w.switch_edge = EDGE_DOWN;
    return w;
  endfunction

  // Random word steered by the predicted state so calibration runs get deep
  function automatic shs_item_t next_word();
    shs_item_t w;
    int roll;
    if ($urandom_range(49) == 0) sim_ms += $urandom_range(0, 2 * sb.timeout_ms + 2);
    else sim_ms += $urandom_range(0, 25);
    w = '0;
    w.func = FN_TICK;
    w.now_ms = sim_ms;
    w.fwd_switch = pick_switch(5);
    w.rev_switch = pick_switch(5);
    w.motor_dir = DIR_STOP;
    w.motor_on = ($urandom_range(9) != 0);
    w.motor_pos = $urandom;
    w.switch_id = 1'($urandom_range(1));
    w.switch_edge = 1'($urandom_range(1));
    roll = $urandom_range(99);
    // noise: any code, any pattern
    if (roll < 8) begin
      w.func = 3'($urandom_range(7));
      w.fwd_switch = 2'($urandom_range(3));
      w.rev_switch = 2'($urandom_range(3));
      w.motor_dir = 2'($urandom_range(3));
      if ($urandom_range(1)) w.now_ms = $urandom;
      return w;
    end
    case (sb.sup)
      ST_NOTVALID, ST_DIRTY, ST_ERROR: begin
        if (roll < 80) w.func = FN_CALIB;
        else if (roll < 88) w.func = $urandom_range(1) ? FN_FWD : FN_REV;
      end
      ST_C_START, ST_C_FWD_START: ;
      ST_C_NEXT: begin
        w.fwd_switch = pick_switch(sb.fwd_done ? 70 : 8);
        w.rev_switch = pick_switch(4);
      end
      ST_C_REV_START: begin
        w.fwd_switch = pick_switch(60);
        w.rev_switch = pick_switch(4);
      end
      ST_C_FWD: begin
        w.motor_dir = ($urandom_range(19) == 0) ? DIR_STOP : DIR_FWD;
        w.fwd_switch = pick_switch(35);
        if (roll >= 92) w.func = FN_SWITCH;
      end
      ST_C_REV: begin
        w.motor_dir = ($urandom_range(19) == 0) ? DIR_STOP : DIR_REV;
        w.rev_switch = pick_switch(35);
        if (roll >= 92) w.func = FN_SWITCH;
      end
      ST_C_FWD_FIN: begin
        w.fwd_switch = pick_switch(90);
        w.motor_dir = ($urandom_range(9) == 0) ? DIR_FWD : DIR_STOP;
      end
      ST_C_REV_FIN: begin
        w.rev_switch = pick_switch(90);
        w.motor_dir = ($urandom_range(9) == 0) ? DIR_REV : DIR_STOP;
      end
      ST_C_FIN: begin
        w.fwd_switch = pick_switch(10);
        w.rev_switch = pick_switch(70);
      end
      default: begin
        // run states: moves, edges, stops and direction changes
        w.fwd_switch = pick_switch(30);
        w.rev_switch = pick_switch(30);
        if (roll < 30) w.func = $urandom_range(1) ? FN_FWD : FN_REV;
        else if (roll < 40) w.func = FN_SWITCH;
        else if (roll < 42) w.func = FN_ESTOP;
        else if (roll < 44) w.func = FN_CALIB;
        else begin
          roll = $urandom_range(99);
          if (roll < 45) w.motor_dir = DIR_STOP;
          else if (roll < 70) w.motor_dir = DIR_FWD;
          else if (roll < 95) w.motor_dir = DIR_REV;
          else w.motor_dir = DIR_MINUS2;
        end
      end
    endcase
    return w;
  endfunction

  // Present one word, hold it until taken, then maybe idle
  task automatic send_word(shs_item_t w);
    int gap;
    in_valid <= 1'b1;
    in_func <= w.func;
    in_now_ms <= w.now_ms;
    in_fwd_switch <= w.fwd_switch;
    in_rev_switch <= w.rev_switch;
    in_motor_dir <= w.motor_dir;
    in_motor_on <= w.motor_on;
    in_motor_pos <= w.motor_pos;
    in_switch_id <= w.switch_id;
    in_switch_edge <= w.switch_edge;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
    words_sent++;
    gap = pick_gap(tx_gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every predicted report
  task automatic wait_idle();
    int spins;
    spins = 0;
    in_valid <= 1'b0;
    while (sb.expected_reports.size() != 0 && spins < 20000) begin
      @(posedge clk);
      spins++;
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  // Write all six registers plus one unused index
  task automatic program_regs(logic [31:0] tmo, logic [31:0] spn, logic [31:0] cspd,
                              logic [31:0] cacc, logic [31:0] rspd, logic [31:0] racc);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_CALIB_SPAN, spn);
    write_reg(CFG_CALIB_SPEED, cspd);
    write_reg(CFG_CALIB_ACCEL, cacc);
    write_reg(CFG_RUN_SPEED, rspd);
    write_reg(CFG_RUN_ACCEL, racc);
    write_reg(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    shs_item_t w;
    int leftover;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: odd codes, faults, a full calibration across the ms wrap
    sim_ms = 32'hFFFF_FFE0;
    send_word(compose_word(FN_TICK, SW_STANDBY, SW_STANDBY, DIR_STOP, '0));
    send_word(compose_word(FN_SPARE6, SW_STANDBY, SW_STANDBY, DIR_STOP, '0));
    send_word(compose_word(FN_SPARE7, SW_ACTIVE, SW_ACTIVE, DIR_FWD, '1));
    send_word(compose_word(FN_FWD, SW_STANDBY, SW_STANDBY, DIR_STOP, '0));
    w = compose_word(FN_SWITCH, SW_STANDBY, SW_STANDBY, DIR_STOP, '0);
    w.switch_id = SWID_REV;
    w.switch_edge = EDGE_UP;
    send_word(w);
    send_word(compose_word(FN_SWITCH, SW_ACTIVE, SW_STANDBY, DIR_STOP, '0));
    send_word(compose_word(FN_ESTOP, SW_STANDBY, SW_STANDBY, DIR_STOP, '0));
    send_word(compose_word(FN_REV, SW_STANDBY, SW_STANDBY, DIR_STOP, '0));
    send_word(compose_word(FN_CALIB, SW_STANDBY, SW_STANDBY, DIR_STOP, '0));
    send_word(compose_word(FN_TICK, SW_STANDBY, SW_STANDBY, DIR_STOP, '0));
    send_word(compose_word(FN_TICK, SW_STANDBY, SW_STANDBY, DIR_STOP, '0));
    send_word(compose_word(FN_TICK, SW_STANDBY, SW_STANDBY, DIR_STOP, '0));
    send_word(compose_word(FN_TICK, SW_STANDBY, SW_STANDBY, DIR_FWD, 32'd100));
    send_word(compose_word(FN_TICK, SW_ACTIVE, SW_STANDBY, DIR_FWD, 32'd200));
    send_word(compose_word(FN_TICK, SW_ACTIVE, SW_STANDBY, DIR_STOP, 32'h7FFF_FFFF));
    send_word(compose_word(FN_TICK, SW_ACTIVE, SW_STANDBY, DIR_STOP, '0));
    send_word(compose_word(FN_TICK, SW_ACTIVE, SW_STANDBY, DIR_STOP, '0));
    send_word(compose_word(FN_TICK, SW_STANDBY, SW_ACTIVE, DIR_REV, '0));
    send_word(compose_word(FN_TICK, SW_STANDBY, SW_ACTIVE, DIR_STOP, 32'h8000_0000));
    send_word(compose_word(FN_TICK, SW_STANDBY, SW_ACTIVE, DIR_STOP, '0));
    // calibration finish with neither switch active stays put
    send_word(compose_word(FN_TICK, SW_STANDBY, SW_STANDBY, DIR_STOP, '0));
    send_word(compose_word(FN_TICK, SW_STANDBY, SW_ACTIVE, DIR_STOP, '0));
    send_word(compose_word(FN_FWD, SW_STANDBY, SW_ACTIVE, DIR_STOP, '0));
    send_word(compose_word(FN_TICK, SW_STANDBY, SW_ACTIVE, DIR_MINUS2, '0));
    send_word(compose_word(FN_TICK, SW_STANDBY, SW_STANDBY, DIR_FWD, '0));
    w = compose_word(FN_TICK, SW_STANDBY, SW_STANDBY, DIR_STOP, '0);
    w.motor_on = 1'b0;
    send_word(w);
    w = compose_word(FN_SWITCH, SW_STANDBY, SW_STANDBY, DIR_STOP, '0);
    w.switch_edge = EDGE_UP;
    send_word(w);

    // random register setting
    wait_idle();
    program_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    repeat (300) send_word(next_word());

    // all registers at their top, no idling on either side
    wait_idle();
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    program_regs('1, '1, '1, '1, '1, '1);
    repeat (250) send_word(next_word());

    // all registers zero, heavy idling
    wait_idle();
    tx_gap_pct = 40;
    rx_stall_pct = 40;
    program_regs('0, '0, '0, '0, '0, '0);
    repeat (200) send_word(next_word());

    // another random setting, with a full drain in the middle
    wait_idle();
    tx_gap_pct = 20;
    rx_stall_pct = 20;
    program_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    repeat (200) send_word(next_word());
    wait_idle();
    repeat (250) send_word(next_word());

    wait_idle();
    repeat (8) @(posedge clk);
    leftover = sb.expected_reports.size();
    if (leftover != 0) begin
      $display("%0d expected reports never arrived", leftover);
      sb.fail_count += leftover;
    end
    $display("covered %0d words under five register settings, %0d reports checked",
             words_sent, sb.checked);
    $display("reached %0d calibration finishes, %0d faults, %0d moves started",
             sb.calib_passes, sb.faults, sb.moves_started);
    if (sb.fail_count == 0) begin
      $display("stepper_axis_homing_supervisor verification clean");
    end else begin
      $display("stepper_axis_homing_supervisor verification failed");
    end
    $finish;
  end

endmodule
